[sv/sbnph_pkg.sv]
// Shared types, widths and register defaults of the spectrum band normaliser.
package sbnph_pkg;

   localparam int MAG_W      = 16;
   localparam int LVL_W      = 16;
   localparam int IDX_W      = 8;
   localparam int GAIN_W     = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int DIV_DVD_W  = 32;
   localparam int DIV_DSR_W  = 16;
   localparam int DIV_Q_W    = 17;
   localparam int DIV_CNT_W  = 5;

   localparam int NUM_BANDS_DEF = 256;

   localparam logic [CSR_DATA_W-1:0] MAX_DECAY_RST      = 16'd65208;
   localparam logic [CSR_DATA_W-1:0] PEAK_DECAY_RST     = 16'd62915;
   localparam logic [CSR_DATA_W-1:0] CUT_THRESHOLD_RST  = 16'd32768;
   localparam logic [CSR_DATA_W-1:0] TILT_INTERCEPT_RST = 16'd4096;
   localparam logic [CSR_DATA_W-1:0] TILT_SLOPE_RST     = 16'd0;
   localparam logic [CSR_DATA_W-1:0] NOISE_FLOOR_RST    = 16'd26;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MAX_DECAY      = 3'd0,
      REG_PEAK_DECAY     = 3'd1,
      REG_CUT_THRESHOLD  = 3'd2,
      REG_TILT_INTERCEPT = 3'd3,
      REG_TILT_SLOPE     = 3'd4,
      REG_NOISE_FLOOR    = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic [LVL_W-1:0]        max_decay;
      logic [LVL_W-1:0]        peak_decay;
      logic [LVL_W-1:0]        cut_threshold;
      logic [LVL_W-1:0]        tilt_intercept;
      logic signed [LVL_W-1:0] tilt_slope;
      logic [LVL_W-1:0]        noise_floor;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic rd;
      logic gstart;
      logic glatch;
      logic scale;
      logic maxc;
      logic nstart;
      logic nlatch;
      logic peak;
      logic astart;
      logic alatch;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic last;
   } stat_type;

   typedef struct packed {
      logic [IDX_W-1:0] band_index;
      logic [LVL_W-1:0] norm_level;
      logic [LVL_W-1:0] peak_level;
      logic             below_threshold;
      logic             frame_done;
      logic [LVL_W-1:0] average_peak;
   } rsp_type;

endpackage

[sv/sbnph_req_if.sv]
// Input channel: band magnitude and frame start flag.
interface sbnph_req_if;
   import sbnph_pkg::*;

   logic             valid;
   logic             ready;
   logic [MAG_W-1:0] magnitude;
   logic             frame_start;

   modport source (output valid, magnitude, frame_start, input ready);
   modport sink (input valid, magnitude, frame_start, output ready);
endinterface

[sv/sbnph_rsp_if.sv]
// Result channel: normalised band, peak hold and frame statistics.
interface sbnph_rsp_if;
   import sbnph_pkg::*;

   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] band_index;
   logic [LVL_W-1:0] norm_level;
   logic [LVL_W-1:0] peak_level;
   logic             below_threshold;
   logic             frame_done;
   logic [LVL_W-1:0] average_peak;

   modport source (output valid, band_index, norm_level, peak_level, below_threshold,
                   frame_done, average_peak, input ready);
   modport sink (input valid, band_index, norm_level, peak_level, below_threshold,
                 frame_done, average_peak, output ready);
endinterface

[sv/sbnph_csr_if.sv]
// Configuration write channel: register index and write data.
interface sbnph_csr_if;
   import sbnph_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[sv/sbnph_div.sv]
// Restoring divider, one quotient bit per cycle, 17-bit quotient.
module sbnph_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [sbnph_pkg::DIV_DVD_W-1:0]   dividend,
   input  logic [sbnph_pkg::DIV_DSR_W-1:0]   divisor,
   output logic                              busy,
   output logic [sbnph_pkg::DIV_Q_W-1:0]     quotient
);
   import sbnph_pkg::*;

   logic                 busy_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_DSR_W-1:0] rem_ff;
   logic [DIV_DSR_W-1:0] rem_in;
   logic [DIV_DSR_W-1:0] dsr_ff;
   logic [DIV_Q_W-1:0]   dq_ff;
   logic [DIV_DSR_W:0]   trial;
   logic [DIV_DSR_W:0]   diff;
   logic                 ge;

   assign trial  = {rem_ff, dq_ff[DIV_Q_W-1]};
   assign diff   = trial - {1'b0, dsr_ff};
   assign ge     = trial >= {1'b0, dsr_ff};
   assign rem_in = ge ? diff[DIV_DSR_W-1:0] : trial[DIV_DSR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= DIV_CNT_W'(DIV_Q_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= DIV_DSR_W'(dividend[DIV_DVD_W-1:DIV_Q_W]);
         dq_ff  <= dividend[DIV_Q_W-1:0];
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dq_ff  <= {dq_ff[DIV_Q_W-2:0], ge};
      end
   end

   assign busy     = busy_ff;
   assign quotient = dq_ff;
endmodule

[sv/sbnph_csr.sv]
// Configuration register bank with reset defaults.
module sbnph_csr (
   input  logic                clock,
   input  logic                reset,
   sbnph_csr_if.sink           csr_chan,
   output sbnph_pkg::cfg_type  cfg
);
   import sbnph_pkg::*;

   cfg_type cfg_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_decay      <= MAX_DECAY_RST;
         cfg_ff.peak_decay     <= PEAK_DECAY_RST;
         cfg_ff.cut_threshold  <= CUT_THRESHOLD_RST;
         cfg_ff.tilt_intercept <= TILT_INTERCEPT_RST;
         cfg_ff.tilt_slope     <= $signed(TILT_SLOPE_RST);
         cfg_ff.noise_floor    <= NOISE_FLOOR_RST;
      end else if (csr_chan.valid) begin
         unique case (csr_idx_type'(csr_chan.index))
            REG_MAX_DECAY:      cfg_ff.max_decay      <= csr_chan.data;
            REG_PEAK_DECAY:     cfg_ff.peak_decay     <= csr_chan.data;
            REG_CUT_THRESHOLD:  cfg_ff.cut_threshold  <= csr_chan.data;
            REG_TILT_INTERCEPT: cfg_ff.tilt_intercept <= csr_chan.data;
            REG_TILT_SLOPE:     cfg_ff.tilt_slope     <= $signed(csr_chan.data);
            REG_NOISE_FLOOR:    cfg_ff.noise_floor    <= csr_chan.data;
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;
endmodule

[sv/sbnph_ctrl.sv]
// Controller state machine sequencing one band through the datapath.
module sbnph_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  sbnph_pkg::stat_type stat,
   output sbnph_pkg::cmd_type  cmd
);
   import sbnph_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE   = 12'b0000_0000_0001,
      S_RD     = 12'b0000_0000_0010,
      S_GSTART = 12'b0000_0000_0100,
      S_GDIV   = 12'b0000_0000_1000,
      S_SCALE  = 12'b0000_0001_0000,
      S_MAX    = 12'b0000_0010_0000,
      S_NSTART = 12'b0000_0100_0000,
      S_NDIV   = 12'b0000_1000_0000,
      S_PEAK   = 12'b0001_0000_0000,
      S_ASTART = 12'b0010_0000_0000,
      S_ADIV   = 12'b0100_0000_0000,
      S_FIN    = 12'b1000_0000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.accept   = (state_ff == S_IDLE) && req_valid;
      cmd.rd       = state_ff == S_RD;
      cmd.gstart   = state_ff == S_GSTART;
      cmd.glatch   = state_ff == S_GDIV;
      cmd.scale    = state_ff == S_SCALE;
      cmd.maxc     = state_ff == S_MAX;
      cmd.nstart   = state_ff == S_NSTART;
      cmd.nlatch   = (state_ff == S_NDIV) && !stat.div_busy;
      cmd.peak     = state_ff == S_PEAK;
      cmd.astart   = state_ff == S_ASTART;
      cmd.alatch   = state_ff == S_ADIV;
      cmd.load_out = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ready);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_RD;
         S_RD:     state_in = S_GSTART;
         S_GSTART: state_in = S_GDIV;
         S_GDIV:   state_in = S_SCALE;
         S_SCALE:  state_in = S_MAX;
         S_MAX:    state_in = S_NSTART;
         S_NSTART: state_in = S_NDIV;
         S_NDIV:   if (!stat.div_busy) state_in = S_PEAK;
         S_PEAK:   state_in = stat.last ? S_ASTART : S_FIN;
         S_ASTART: state_in = S_ADIV;
         S_ADIV:   state_in = S_FIN;
         S_FIN:    if (cmd.load_out) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;
endmodule

[sv/sbnph_dp.sv]
// Datapath: tilt gain, band stores, divider, peak hold and frame mean.
module sbnph_dp #(
   parameter int NUM_BANDS = sbnph_pkg::NUM_BANDS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sbnph_pkg::cfg_type            cfg,
   input  sbnph_pkg::cmd_type            cmd,
   output sbnph_pkg::stat_type           stat,
   input  logic [sbnph_pkg::MAG_W-1:0]   req_magnitude,
   input  logic                          req_frame_start,
   output sbnph_pkg::rsp_type            rsp_data
);
   import sbnph_pkg::*;

   localparam int POS_W  = $clog2(NUM_BANDS);
   localparam int SUM_W  = LVL_W + POS_W;
   localparam int NUM_W  = POS_W + 18;
   localparam int PG_W   = MAG_W + GAIN_W;
   localparam int GAIN_K = NUM_W + $clog2(NUM_BANDS - 1);
   localparam int AVG_K  = SUM_W + POS_W;
   // ceil(2^K / d): exact floor division for every numerator below 2^N
   localparam longint GAIN_RECIP_L =
      ((longint'(1) << GAIN_K) + longint'(NUM_BANDS - 2)) / longint'(NUM_BANDS - 1);
   localparam longint AVG_RECIP_L =
      ((longint'(1) << AVG_K) + longint'(NUM_BANDS - 1)) / longint'(NUM_BANDS);
   localparam logic [POS_W-1:0] SPAN       = POS_W'(NUM_BANDS - 1);
   localparam logic [NUM_W:0]   GAIN_RECIP = GAIN_RECIP_L[NUM_W:0];
   localparam logic [SUM_W:0]   AVG_RECIP  = AVG_RECIP_L[SUM_W:0];

   logic [LVL_W-1:0] max_mem  [NUM_BANDS];
   logic [LVL_W-1:0] peak_mem [NUM_BANDS];

   logic [POS_W-1:0]        pos_ff;
   logic [POS_W:0]          fill_ff;
   logic [SUM_W-1:0]        sum_ff;
   logic [MAG_W-1:0]        mag_ff;
   logic [POS_W+15:0]       prod_i_ff;
   logic signed [POS_W+16:0] prod_s_ff;
   logic                    hit_ff;
   logic [LVL_W-1:0]        max_rd_ff;
   logic [LVL_W-1:0]        peak_rd_ff;
   logic [NUM_W-1:0]        num_ff;
   logic [GAIN_W-1:0]       gain_ff;
   logic [PG_W-1:0]         prod_g_ff;
   logic [LVL_W-1:0]        scaled_ff;
   logic [LVL_W-1:0]        m_ff;
   logic [2*LVL_W-1:0]      max_prod_ff;
   logic [2*LVL_W-1:0]      peak_prod_ff;
   logic [LVL_W-1:0]        norm_ff;
   logic [LVL_W-1:0]        pk_ff;
   logic [2*SUM_W:0]        aprod_ff;
   logic [LVL_W-1:0]        avg_ff;
   rsp_type                 rsp_ff;

   logic signed [NUM_W-1:0] num;
   logic [NUM_W-1:0]        num_pos;
   logic [2*NUM_W:0]        gprod;
   logic [LVL_W-1:0]        scaled_in;
   logic [LVL_W-1:0]        stored_max;
   logic [LVL_W-1:0]        m_in;
   logic [LVL_W-1:0]        peak_old;
   logic [LVL_W-1:0]        norm_in;
   logic [LVL_W-1:0]        peak_dec;
   logic [LVL_W-1:0]        pk_in;
   logic                    last;

   logic                    div_start;
   logic [DIV_DVD_W-1:0]    div_dvd;
   logic [DIV_DSR_W-1:0]    div_dsr;
   logic                    div_busy;
   logic [DIV_Q_W-1:0]      div_quot;

   assign num     = $signed({2'b00, prod_i_ff}) + NUM_W'(prod_s_ff);
   assign num_pos = (!num[NUM_W-1] && (num != '0)) ? num : '0;
   assign gprod   = num_ff * GAIN_RECIP;

   assign scaled_in  = (|prod_g_ff[PG_W-1:28]) ? '1 : prod_g_ff[27:12];
   assign stored_max = hit_ff ? max_rd_ff : '0;
   assign m_in       = (stored_max > scaled_in) ? stored_max : scaled_in;
   assign peak_old   = hit_ff ? peak_rd_ff : '0;

   assign norm_in = ((m_ff == '0) || (scaled_ff < cfg.noise_floor)) ? '0 :
                    (div_quot[DIV_Q_W-1] ? '1 : div_quot[LVL_W-1:0]);
   assign peak_dec = peak_prod_ff[2*LVL_W-1:LVL_W];
   assign pk_in    = (peak_dec > norm_ff) ? peak_dec : norm_ff;
   assign last     = pos_ff == SPAN;

   assign div_start = cmd.nstart;
   assign div_dvd   = {scaled_ff, {LVL_W{1'b0}}};
   assign div_dsr   = m_ff;

   sbnph_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .busy     (div_busy),
      .quotient (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         sum_ff  <= '0;
         fill_ff <= '0;
      end else if (cmd.accept) begin
         if (req_frame_start) begin
            pos_ff <= '0;
            sum_ff <= '0;
         end
      end else if (cmd.peak) begin
         sum_ff <= sum_ff + SUM_W'(pk_in);
         if ({1'b0, pos_ff} == fill_ff) begin
            fill_ff <= fill_ff + 1'b1;
         end
      end else if (cmd.load_out) begin
         if (last) begin
            pos_ff <= '0;
            sum_ff <= '0;
         end else begin
            pos_ff <= pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mag_ff <= req_magnitude;
      end
      if (cmd.rd) begin
         prod_i_ff  <= cfg.tilt_intercept * SPAN;
         prod_s_ff  <= $signed(cfg.tilt_slope) * $signed({1'b0, pos_ff});
         hit_ff     <= {1'b0, pos_ff} < fill_ff;
         max_rd_ff  <= max_mem[pos_ff];
         peak_rd_ff <= peak_mem[pos_ff];
      end
      if (cmd.gstart) begin
         num_ff <= num_pos;
      end
      if (cmd.glatch) begin
         gain_ff <= gprod[GAIN_K +: GAIN_W];
      end
      if (cmd.scale) begin
         prod_g_ff <= mag_ff * gain_ff;
      end
      if (cmd.maxc) begin
         scaled_ff <= scaled_in;
         m_ff      <= m_in;
      end
      if (cmd.nstart) begin
         max_prod_ff  <= m_ff * cfg.max_decay;
         peak_prod_ff <= peak_old * cfg.peak_decay;
      end
      if (cmd.nlatch) begin
         norm_ff         <= norm_in;
         max_mem[pos_ff] <= max_prod_ff[2*LVL_W-1:LVL_W];
      end
      if (cmd.peak) begin
         pk_ff            <= pk_in;
         peak_mem[pos_ff] <= pk_in;
      end
      if (cmd.astart) begin
         aprod_ff <= sum_ff * AVG_RECIP;
      end
      if (cmd.alatch) begin
         avg_ff <= aprod_ff[AVG_K +: LVL_W];
      end
      if (cmd.load_out) begin
         rsp_ff.band_index      <= IDX_W'(pos_ff);
         rsp_ff.norm_level      <= norm_ff;
         rsp_ff.peak_level      <= pk_ff;
         rsp_ff.below_threshold <= pk_ff < cfg.cut_threshold;
         rsp_ff.frame_done      <= last;
         rsp_ff.average_peak    <= last ? avg_ff : '0;
      end
   end

   assign stat.div_busy = div_busy;
   assign stat.last     = last;
   assign rsp_data      = rsp_ff;
endmodule

[sv/spectrum_band_normalise_peak_hold_top.sv]
// Top level: spectrum band normaliser with decaying maximum and peak hold.
// Sequence per band: read, tilt gain by reciprocal multiply, scale, maximum, normalization
// by the restoring divider (held while it is busy), peak hold, frame mean by reciprocal
// multiply on the last band only, then result load; the next band is taken after that load.
// Reset: synchronous; restores register defaults and empties both band stores at once
// through a fill count, so no clearing pass is needed.
module spectrum_band_normalise_peak_hold_top #(
   parameter int NUM_BANDS = sbnph_pkg::NUM_BANDS_DEF
) (
   input logic         clock,
   input logic         reset,
   sbnph_req_if.sink   req_chan,
   sbnph_rsp_if.source rsp_chan,
   sbnph_csr_if.sink   csr_chan
);
   import sbnph_pkg::*;

   cfg_type  cfg;
   cmd_type  cmd;
   stat_type stat;
   rsp_type  rsp_data;
   logic     rsp_valid;
   logic     req_ready;

   sbnph_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   sbnph_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sbnph_dp #(
      .NUM_BANDS (NUM_BANDS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .stat            (stat),
      .req_magnitude   (req_chan.magnitude),
      .req_frame_start (req_chan.frame_start),
      .rsp_data        (rsp_data)
   );

   assign req_chan.ready           = req_ready;
   assign rsp_chan.valid           = rsp_valid;
   assign rsp_chan.band_index      = rsp_data.band_index;
   assign rsp_chan.norm_level      = rsp_data.norm_level;
   assign rsp_chan.peak_level      = rsp_data.peak_level;
   assign rsp_chan.below_threshold = rsp_data.below_threshold;
   assign rsp_chan.frame_done      = rsp_data.frame_done;
   assign rsp_chan.average_peak    = rsp_data.average_peak;
endmodule
